[rtl/lcd_line_timing_generator_top_defines.svh]
// Assertion macros for the LCD line timing generator.
`ifndef LCD_LINE_TIMING_GENERATOR_TOP_DEFINES_SVH
`define LCD_LINE_TIMING_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCDLTG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdltg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LCDLTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdltg: next-cycle check failed");

`endif

[rtl/lcdltg_pkg.sv]
// Package with the types, codes and constants of the LCD line timing generator.
`default_nettype none

package lcdltg_pkg;

   localparam logic [11:0] LINE_CYCLES        = 12'd960;
   localparam logic [11:0] HBLANK_CYCLES      = 12'd272;
   localparam logic [11:0] VBLANK_LINE_CYCLES = 12'd1232;

   localparam logic [7:0] VBLANK_START_LINE = 8'd160;
   localparam logic [7:0] LAST_LINE         = 8'd227;
   localparam logic [7:0] VBLANK_END_LINE   = 8'd226;

   localparam int REF_WIDTH = 28;
   localparam int NUM_REFS  = 4;
   localparam int NUM_LAYERS = 2;

   // Bit positions in the status flags and interrupt pulses.
   localparam int FLAG_VBL   = 0;
   localparam int FLAG_HBL   = 1;
   localparam int FLAG_MATCH = 2;

   // Bit positions in the interrupt enable register.
   localparam int EN_HBL   = 0;
   localparam int EN_VBL   = 1;
   localparam int EN_MATCH = 2;

   typedef enum logic [2:0] {
      PH_VISIBLE = 3'b001,
      PH_HBLANK  = 3'b010,
      PH_VBLANK  = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      PHASE_CODE_VISIBLE = 2'd0,
      PHASE_CODE_HBLANK  = 2'd1,
      PHASE_CODE_VBLANK  = 2'd2
   } phase_code_type;

   typedef enum logic [1:0] {
      DMA_NONE   = 2'd0,
      DMA_HBLANK = 2'd1,
      DMA_VBLANK = 2'd2
   } dma_type;

   typedef enum logic [2:0] {
      REG_LINE_MATCH = 3'd0,
      REG_IRQ_EN     = 3'd1,
      REG_STEP_0     = 3'd2,
      REG_STEP_1     = 3'd3,
      REG_START_X_0  = 3'd4,
      REG_START_Y_0  = 3'd5,
      REG_START_X_1  = 3'd6,
      REG_START_Y_1  = 3'd7
   } reg_index_type;

   typedef logic [REF_WIDTH-1:0] ref_type;

   function automatic phase_code_type phase_code(input phase_type ph);
      phase_code_type code;
      case (ph)
         PH_HBLANK: code = PHASE_CODE_HBLANK;
         PH_VBLANK: code = PHASE_CODE_VBLANK;
         default:   code = PHASE_CODE_VISIBLE;
      endcase
      return code;
   endfunction

   function automatic logic [11:0] phase_wait(input phase_type ph);
      logic [11:0] cycles;
      case (ph)
         PH_HBLANK: cycles = HBLANK_CYCLES;
         PH_VBLANK: cycles = VBLANK_LINE_CYCLES;
         default:   cycles = LINE_CYCLES;
      endcase
      return cycles;
   endfunction

   function automatic ref_type sext_step(input logic [15:0] s);
      return {{(REF_WIDTH-16){s[15]}}, s};
   endfunction

endpackage

`default_nettype wire

[rtl/lcd_line_timing_generator_top.sv]
// Top level of the LCD line timing generator: phase sequencing, flags and affine references.
// A taken request is registered; its response is valid in the next cycle.
// Throughput: one request per cycle through the single step logic; a new request is taken
// in the cycle that the held response leaves, and the input stalls while a response waits.
// A request with phase_done clear changes nothing and gives no response.
// Reset is synchronous and active high; it clears timing state, configuration and response valid.
`default_nettype none

`include "lcd_line_timing_generator_top_defines.svh"

module lcd_line_timing_generator_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_phase_done,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_next_phase,
   output logic [7:0]                         rsp_line_number,
   output logic [2:0]                         rsp_status_flags,
   output logic [2:0]                         rsp_irq_raise,
   output logic [1:0]                         rsp_dma_request,
   output logic                               rsp_render_line,
   output logic [11:0]                        rsp_wait_cycles,
   output logic signed [lcdltg_pkg::REF_WIDTH-1:0] rsp_cur_x_0,
   output logic signed [lcdltg_pkg::REF_WIDTH-1:0] rsp_cur_y_0,
   output logic signed [lcdltg_pkg::REF_WIDTH-1:0] rsp_cur_x_1,
   output logic signed [lcdltg_pkg::REF_WIDTH-1:0] rsp_cur_y_1,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [4:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   import lcdltg_pkg::*;

   // Configuration registers.
   logic [7:0]  match_ff;
   logic [2:0]  enables_ff;
   logic [31:0] step_ff  [NUM_LAYERS];
   ref_type     start_ff [NUM_REFS];

   // Timing state.
   phase_type   phase_ff, phase_in;
   logic [7:0]  line_ff, line_in;
   logic [2:0]  flags_ff, flags_in;
   ref_type     ref_ff [NUM_REFS];
   ref_type     ref_in [NUM_REFS];

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  next_phase_ff;
   logic [7:0]  line_out_ff;
   logic [2:0]  flags_out_ff;
   logic [2:0]  irq_ff, irq_in;
   logic [1:0]  dma_ff;
   dma_type     dma_in;
   logic        render_ff, render_in;
   logic [11:0] wait_ff;
   ref_type     ref_out_ff [NUM_REFS];

   logic          csr_write;
   reg_index_type csr_index;
   logic          step;

   assign csr_index = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff   <= '0;
         enables_ff <= '0;
         for (int i = 0; i < NUM_LAYERS; i++) begin
            step_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_REFS; i++) begin
            start_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_LINE_MATCH: match_ff    <= pwdata[7:0];
            REG_IRQ_EN:     enables_ff  <= pwdata[2:0];
            REG_STEP_0:     step_ff[0]  <= pwdata;
            REG_STEP_1:     step_ff[1]  <= pwdata;
            REG_START_X_0:  start_ff[0] <= pwdata[REF_WIDTH-1:0];
            REG_START_Y_0:  start_ff[1] <= pwdata[REF_WIDTH-1:0];
            REG_START_X_1:  start_ff[2] <= pwdata[REF_WIDTH-1:0];
            REG_START_Y_1:  start_ff[3] <= pwdata[REF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LINE_MATCH: prdata = {24'd0, match_ff};
         REG_IRQ_EN:     prdata = {29'd0, enables_ff};
         REG_STEP_0:     prdata = step_ff[0];
         REG_STEP_1:     prdata = step_ff[1];
         REG_START_X_0:  prdata = {{(32-REF_WIDTH){1'b0}}, start_ff[0]};
         REG_START_Y_0:  prdata = {{(32-REF_WIDTH){1'b0}}, start_ff[1]};
         REG_START_X_1:  prdata = {{(32-REF_WIDTH){1'b0}}, start_ff[2]};
         REG_START_Y_1:  prdata = {{(32-REF_WIDTH){1'b0}}, start_ff[3]};
         default:        prdata = '0;
      endcase
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready && req_phase_done;

   always_comb begin
      phase_in  = phase_ff;
      line_in   = line_ff;
      flags_in  = flags_ff;
      irq_in    = '0;
      dma_in    = DMA_NONE;
      render_in = 1'b0;
      for (int i = 0; i < NUM_REFS; i++) begin
         ref_in[i] = ref_ff[i];
      end

      case (phase_ff)
         PH_HBLANK: begin
            flags_in[FLAG_HBL]   = 1'b0;
            line_in              = line_ff + 8'd1;
            flags_in[FLAG_MATCH] = (line_in == match_ff);
            irq_in[FLAG_MATCH]   = flags_in[FLAG_MATCH] && enables_ff[EN_MATCH];
            if (line_in == VBLANK_START_LINE) begin
               dma_in             = DMA_VBLANK;
               flags_in[FLAG_VBL] = 1'b1;
               phase_in           = PH_VBLANK;
               irq_in[FLAG_VBL]   = enables_ff[EN_VBL];
               for (int i = 0; i < NUM_REFS; i++) begin
                  ref_in[i] = start_ff[i];
               end
            end else begin
               phase_in  = PH_VISIBLE;
               render_in = 1'b1;
               for (int i = 0; i < NUM_LAYERS; i++) begin
                  ref_in[2*i]   = ref_ff[2*i]   + sext_step(step_ff[i][15:0]);
                  ref_in[2*i+1] = ref_ff[2*i+1] + sext_step(step_ff[i][31:16]);
               end
            end
         end
         PH_VBLANK: begin
            if (line_ff == LAST_LINE) begin
               phase_in             = PH_VISIBLE;
               line_in              = '0;
               flags_in[FLAG_MATCH] = (match_ff == 8'd0);
               render_in            = 1'b1;
            end else begin
               if (line_ff == VBLANK_END_LINE) begin
                  flags_in[FLAG_VBL] = 1'b0;
               end
               line_in              = line_ff + 8'd1;
               flags_in[FLAG_MATCH] = (line_in == match_ff);
            end
            irq_in[FLAG_MATCH] = flags_in[FLAG_MATCH] && enables_ff[EN_MATCH];
         end
         default: begin
            dma_in             = DMA_HBLANK;
            phase_in           = PH_HBLANK;
            flags_in[FLAG_HBL] = 1'b1;
            irq_in[FLAG_HBL]   = enables_ff[EN_HBL];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VISIBLE;
         line_ff  <= '0;
         flags_ff <= '0;
         for (int i = 0; i < NUM_REFS; i++) begin
            ref_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         flags_ff <= flags_in;
         for (int i = 0; i < NUM_REFS; i++) begin
            ref_ff[i] <= ref_in[i];
         end
      end
   end

   always_comb begin
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         next_phase_ff <= phase_code(phase_in);
         line_out_ff   <= line_in;
         flags_out_ff  <= flags_in;
         irq_ff        <= irq_in;
         dma_ff        <= dma_in;
         render_ff     <= render_in;
         wait_ff       <= phase_wait(phase_in);
         for (int i = 0; i < NUM_REFS; i++) begin
            ref_out_ff[i] <= ref_in[i];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_phase   = next_phase_ff;
   assign rsp_line_number  = line_out_ff;
   assign rsp_status_flags = flags_out_ff;
   assign rsp_irq_raise    = irq_ff;
   assign rsp_dma_request  = dma_ff;
   assign rsp_render_line  = render_ff;
   assign rsp_wait_cycles  = wait_ff;
   assign rsp_cur_x_0      = ref_out_ff[0];
   assign rsp_cur_y_0      = ref_out_ff[1];
   assign rsp_cur_x_1      = ref_out_ff[2];
   assign rsp_cur_y_1      = ref_out_ff[3];

   `LCDLTG_ASSERT_IMPLY(a_line_in_range, clock, reset, 1'b1, line_ff <= LAST_LINE)
   `LCDLTG_ASSERT_NEXT(a_hblank_advances_line, clock, reset,
      step && (phase_ff == PH_HBLANK), rsp_line_number == ($past(line_ff) + 8'd1))
   `LCDLTG_ASSERT_IMPLY(a_hblank_dma_phase, clock, reset,
      rsp_valid_ff && (rsp_dma_request == DMA_HBLANK),
      (rsp_next_phase == PHASE_CODE_HBLANK) && rsp_status_flags[FLAG_HBL])
   `LCDLTG_ASSERT_IMPLY(a_render_on_visible, clock, reset,
      rsp_valid_ff && rsp_render_line, rsp_next_phase == PHASE_CODE_VISIBLE)

endmodule

`default_nettype wire

[test/lcd_line_timing_generator_top_tb.sv]
// Self-checking testbench for the LCD line timing generator: phase sequencing, flags and references.
`timescale 1ns / 1ps

module lcd_line_timing_generator_top_tb;
   import lcdltg_pkg::*;

   typedef struct packed {
      phase_code_type next_phase;
      logic [7:0]     line_number;
      logic [2:0]     status_flags;
      logic [2:0]     irq_raise;
      dma_type        dma_request;
      logic           render_line;
      logic [11:0]    wait_cycles;
      ref_type        cur_x_0;
      ref_type        cur_y_0;
      ref_type        cur_x_1;
      ref_type        cur_y_1;
   } line_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_phase_done = 1'b0;
   logic        rsp_ready = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;

   logic                req_ready;
   logic                rsp_valid;
   logic [1:0]          rsp_next_phase;
   logic [7:0]          rsp_line_number;
   logic [2:0]          rsp_status_flags;
   logic [2:0]          rsp_irq_raise;
   logic [1:0]          rsp_dma_request;
   logic                rsp_render_line;
   logic [11:0]         rsp_wait_cycles;
   logic [REF_WIDTH-1:0] rsp_cur_x_0;
   logic [REF_WIDTH-1:0] rsp_cur_y_0;
   logic [REF_WIDTH-1:0] rsp_cur_x_1;
   logic [REF_WIDTH-1:0] rsp_cur_y_1;
   logic [31:0]         prdata;
   logic                pready;

   // Predicted timing state and configuration.
   phase_code_type timing_phase = PHASE_CODE_VISIBLE;
   logic [7:0]     timing_line = '0;
   logic [2:0]     timing_flags = '0;
   ref_type        ref_acc [NUM_REFS];
   logic [7:0]     cfg_match = '0;
   logic [2:0]     cfg_enables = '0;
   logic [31:0]    cfg_step [NUM_LAYERS];
   ref_type        cfg_start [NUM_REFS];

   line_result_t expected_lines [$];

   int error_count = 0;
   int phase_ends = 0;
   int ignored_requests = 0;
   int responses_checked = 0;
   int frames_started = 0;
   int irq_pulses = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   lcd_line_timing_generator_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_phase_done   (req_phase_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_phase   (rsp_next_phase),
      .rsp_line_number  (rsp_line_number),
      .rsp_status_flags (rsp_status_flags),
      .rsp_irq_raise    (rsp_irq_raise),
      .rsp_dma_request  (rsp_dma_request),
      .rsp_render_line  (rsp_render_line),
      .rsp_wait_cycles  (rsp_wait_cycles),
      .rsp_cur_x_0      (rsp_cur_x_0),
      .rsp_cur_y_0      (rsp_cur_y_0),
      .rsp_cur_x_1      (rsp_cur_x_1),
      .rsp_cur_y_1      (rsp_cur_y_1),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   function automatic void next_line();
      timing_line = timing_line + 8'd1;
      timing_flags[FLAG_MATCH] = (timing_line == cfg_match);
   endfunction

   function automatic line_result_t advance_timing();
      line_result_t r;
      logic [2:0]   irq;
      dma_type      dma;
      logic         render;
      int           k;
      irq = '0;
      dma = DMA_NONE;
      render = 1'b0;
      case (timing_phase)
         PHASE_CODE_HBLANK: begin
            timing_flags[FLAG_HBL] = 1'b0;
            next_line();
            if (timing_flags[FLAG_MATCH] && cfg_enables[EN_MATCH]) irq[FLAG_MATCH] = 1'b1;
            if (timing_line == VBLANK_START_LINE) begin
               dma = DMA_VBLANK;
               timing_flags[FLAG_VBL] = 1'b1;
               timing_phase = PHASE_CODE_VBLANK;
               if (cfg_enables[EN_VBL]) irq[FLAG_VBL] = 1'b1;
               for (k = 0; k < NUM_REFS; k++) ref_acc[k] = cfg_start[k];
            end else begin
               timing_phase = PHASE_CODE_VISIBLE;
               render = 1'b1;
               for (k = 0; k < NUM_LAYERS; k++) begin
                  ref_acc[2*k] = ref_acc[2*k]
                     + {{(REF_WIDTH-16){cfg_step[k][15]}}, cfg_step[k][15:0]};
                  ref_acc[2*k+1] = ref_acc[2*k+1]
                     + {{(REF_WIDTH-16){cfg_step[k][31]}}, cfg_step[k][31:16]};
               end
            end
         end
         PHASE_CODE_VBLANK: begin
            if (timing_line == LAST_LINE) begin
               timing_phase = PHASE_CODE_VISIBLE;
               timing_line = '0;
               timing_flags[FLAG_MATCH] = (cfg_match == 8'd0);
               render = 1'b1;
            end else begin
               if (timing_line == VBLANK_END_LINE) timing_flags[FLAG_VBL] = 1'b0;
               next_line();
            end
            if (timing_flags[FLAG_MATCH] && cfg_enables[EN_MATCH]) irq[FLAG_MATCH] = 1'b1;
         end
         default: begin
            dma = DMA_HBLANK;
            timing_phase = PHASE_CODE_HBLANK;
            timing_flags[FLAG_HBL] = 1'b1;
            if (cfg_enables[EN_HBL]) irq[FLAG_HBL] = 1'b1;
         end
      endcase
      case (timing_phase)
         PHASE_CODE_VISIBLE: r.wait_cycles = LINE_CYCLES;
         PHASE_CODE_HBLANK:  r.wait_cycles = HBLANK_CYCLES;
         default:            r.wait_cycles = VBLANK_LINE_CYCLES;
      endcase
      r.next_phase = timing_phase;
      r.line_number = timing_line;
      r.status_flags = timing_flags;
      r.irq_raise = irq;
      r.dma_request = dma;
      r.render_line = render;
      r.cur_x_0 = ref_acc[0];
      r.cur_y_0 = ref_acc[1];
      r.cur_x_1 = ref_acc[2];
      r.cur_y_1 = ref_acc[3];
      if (dma == DMA_VBLANK) frames_started++;
      if (irq != '0) irq_pulses++;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_LINE_MATCH: cfg_match = value[7:0];
         REG_IRQ_EN:     cfg_enables = value[2:0];
         REG_STEP_0:     cfg_step[0] = value;
         REG_STEP_1:     cfg_step[1] = value;
         REG_START_X_0:  cfg_start[0] = value[REF_WIDTH-1:0];
         REG_START_Y_0:  cfg_start[1] = value[REF_WIDTH-1:0];
         REG_START_X_1:  cfg_start[2] = value[REF_WIDTH-1:0];
         default:        cfg_start[3] = value[REF_WIDTH-1:0];
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] match, input logic [31:0] enables,
                             input logic [31:0] step_0, input logic [31:0] step_1,
                             input logic [31:0] sx_0, input logic [31:0] sy_0,
                             input logic [31:0] sx_1, input logic [31:0] sy_1);
      write_register(REG_LINE_MATCH, match);
      write_register(REG_IRQ_EN, enables);
      write_register(REG_STEP_0, step_0);
      write_register(REG_STEP_1, step_1);
      write_register(REG_START_X_0, sx_0);
      write_register(REG_START_Y_0, sy_0);
      write_register(REG_START_X_1, sx_1);
      write_register(REG_START_Y_1, sy_1);
   endtask

   task automatic send_request(input logic done);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(3);
         @(negedge clock);
         req_valid <= 1'b0;
         req_phase_done <= $urandom_range(1);
         repeat (gap) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_phase_done <= done;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (done) begin
         expected_lines.push_back(advance_timing());
         phase_ends++;
      end else begin
         ignored_requests++;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_frames(input int count, input int hold);
      int sent;
      sent = 0;
      if (hold > 0) hold_left = hold;
      while (sent < count) begin
         if ($urandom_range(19) == 0) begin
            send_request(1'b0);
         end else begin
            send_request(1'b1);
            sent++;
         end
      end
      drain();
   endtask

   task automatic test_ignored_requests();
      repeat (3) send_request(1'b0);
      drain();
   endtask

   task automatic test_first_lines();
      repeat (6) send_request(1'b1);
      drain();
   endtask

   task automatic test_line_match_irq();
      set_config(32'd3, 32'd7, 32'h8000_7FFF, 32'h7FFF_8000,
                 32'h0800_0000, 32'h07FF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(1'b1);
      send_request(1'b0);
      repeat (7) send_request(1'b1);
      drain();
   endtask

   task automatic test_frames_low_extremes();
      set_config(32'd0, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hF800_0000, 32'h0800_0000, 32'hF800_0000, 32'h0800_0000);
      run_frames(390, 0);
   endtask

   task automatic test_frames_high_extremes();
      send_idle_pct = 52;
      recv_idle_pct = 24;
      set_config(32'd255, 32'd0, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                 32'h07FF_FFFF, 32'hF7FF_FFFF, 32'h07FF_FFFF, 32'h07FF_FFFF);
      run_frames(390, 300);
   endtask

   task automatic test_frames_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config($urandom_range(LAST_LINE), $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
      run_frames(390, 0);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      line_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_checked++;
         if (expected_lines.size() == 0) begin
            $error("response with no request waiting for it");
            error_count++;
         end else begin
            want = expected_lines.pop_front();
            check_field("next_phase", want.next_phase, rsp_next_phase);
            check_field("line_number", want.line_number, rsp_line_number);
            check_field("status_flags", want.status_flags, rsp_status_flags);
            check_field("irq_raise", want.irq_raise, rsp_irq_raise);
            check_field("dma_request", want.dma_request, rsp_dma_request);
            check_field("render_line", want.render_line, rsp_render_line);
            check_field("wait_cycles", want.wait_cycles, rsp_wait_cycles);
            check_field("cur_x_0", want.cur_x_0, rsp_cur_x_0);
            check_field("cur_y_0", want.cur_y_0, rsp_cur_y_0);
            check_field("cur_x_1", want.cur_x_1, rsp_cur_x_1);
            check_field("cur_y_1", want.cur_y_1, rsp_cur_y_1);
         end
      end
   end

   initial begin
      for (int k = 0; k < NUM_REFS; k++) begin
         ref_acc[k] = '0;
         cfg_start[k] = '0;
      end
      for (int k = 0; k < NUM_LAYERS; k++) cfg_step[k] = '0;
      send_idle_pct = 24;
      recv_idle_pct = 52;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_requests();
      test_first_lines();
      test_line_match_irq();
      test_frames_low_extremes();
      test_frames_high_extremes();
      test_frames_random();

      if (expected_lines.size() != 0) begin
         $error("%0d responses never arrived", expected_lines.size());
         error_count++;
      end
      $display("Run covered %0d phase ends and %0d ignored requests; %0d responses checked.",
               phase_ends, ignored_requests, responses_checked);
      $display("Vertical blank starts: %0d, steps with interrupt pulses: %0d.",
               frames_started, irq_pulses);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
